### rtl/dnv_pkg.sv
// Shared types, constants and a helper function for the domain name validator.
`timescale 1ns / 1ps

package dnv_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned NAME_LEN_W  = 8;
  localparam int unsigned LABEL_LEN_W = 6;
  localparam int unsigned NAME_CNT_W  = 9;
  localparam int unsigned LABEL_CNT_W = 7;
  localparam int unsigned FAULT_W     = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [NAME_CNT_W-1:0]  NAME_CNT_MAX  = '1;
  localparam logic [LABEL_CNT_W-1:0] LABEL_CNT_MAX = '1;

  localparam logic [NAME_LEN_W-1:0]  MAX_NAME_RESET  = 8'd255;
  localparam logic [LABEL_LEN_W-1:0] MAX_LABEL_RESET = 6'd63;

  localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 1'b1;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE      = 3'd0,
    FAULT_LENGTH    = 3'd1,
    FAULT_EMPTY     = 3'd2,
    FAULT_LONG      = 3'd3,
    FAULT_BADCHAR   = 3'd4,
    FAULT_LEADHYPH  = 3'd5,
    FAULT_TRAILHYPH = 3'd6
  } fault_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              end_of_name;
    logic              empty_name;
  } in_item_t;

  typedef struct packed {
    logic   name_ok;
    fault_t fault;
  } verdict_t;

  typedef struct packed {
    logic     has_result;
    verdict_t verdict;
  } track_out_t;

  // Letters, digits and the hyphen are the only legal label characters.
  function automatic logic is_ldh(input logic [CHAR_W-1:0] c);
    logic lower;
    logic upper;
    logic digit;
    lower = (c >= 8'h61) && (c <= 8'h7A);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return lower || upper || digit || (c == CHAR_HYPHEN);
  endfunction

endpackage

### rtl/dnv_in_if.sv
// Input channel of the domain name validator: one name byte per beat.
`timescale 1ns / 1ps

interface dnv_in_if;
  logic                          valid;
  logic                          ready;
  logic [dnv_pkg::CHAR_W-1:0]    char_byte;
  logic                          end_of_name;
  logic                          empty_name;

  modport source (output valid, output char_byte, output end_of_name,
                  output empty_name, input ready);
  modport sink   (input valid, input char_byte, input end_of_name,
                  input empty_name, output ready);
endinterface

### rtl/dnv_out_if.sv
// Result channel of the domain name validator: one verdict per beat.
`timescale 1ns / 1ps

interface dnv_out_if;
  logic                          valid;
  logic                          ready;
  logic                          name_ok;
  logic [dnv_pkg::FAULT_W-1:0]   fault_code;

  modport source (output valid, output name_ok, output fault_code, input ready);
  modport sink   (input valid, input name_ok, input fault_code, output ready);
endinterface

### rtl/dnv_in_reg.sv
// Input register stage that captures one byte beat per cycle while it is empty or its held byte is taken.
`timescale 1ns / 1ps

module dnv_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  dnv_in_if.sink            in_beat,
  input  logic              take,
  output logic              valid_r,
  output dnv_pkg::in_item_t item_r
);

  logic load;

  assign in_beat.ready = !valid_r || take;
  assign load          = in_beat.valid && in_beat.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.char_byte   <= in_beat.char_byte;
      item_r.end_of_name <= in_beat.end_of_name;
      item_r.empty_name  <= in_beat.empty_name;
    end
  end

endmodule

### rtl/dnv_track.sv
// Per-name counters, byte flags and fault tracking, with the verdict logic.
`timescale 1ns / 1ps

module dnv_track (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  dnv_pkg::in_item_t                   item,
  input  logic [dnv_pkg::NAME_LEN_W-1:0]      max_name_len,
  input  logic [dnv_pkg::LABEL_LEN_W-1:0]     max_label_len,
  output dnv_pkg::track_out_t                 track
);

  logic [dnv_pkg::NAME_CNT_W-1:0]  name_cnt_r,  name_cnt_nxt;
  logic [dnv_pkg::LABEL_CNT_W-1:0] label_cnt_r, label_cnt_nxt;
  logic                            after_dot_r, after_dot_nxt;
  logic                            hyphen_r,    hyphen_nxt;
  dnv_pkg::fault_t                 fault_r,     fault_nxt;

  // Fault raised when a label closes, given the label state at that point.
  function automatic dnv_pkg::fault_t close_label(
    input logic                            after_dot,
    input logic [dnv_pkg::LABEL_CNT_W-1:0] label_cnt,
    input logic                            hyphen,
    input logic [dnv_pkg::LABEL_LEN_W-1:0] max_label
  );
    dnv_pkg::fault_t f;
    if (after_dot) begin
      f = dnv_pkg::FAULT_EMPTY;
    end else if (label_cnt > {1'b0, max_label}) begin
      f = dnv_pkg::FAULT_LONG;
    end else if (hyphen) begin
      f = dnv_pkg::FAULT_TRAILHYPH;
    end else begin
      f = dnv_pkg::FAULT_NONE;
    end
    return f;
  endfunction

  logic                            is_dot;
  logic                            is_hyph;
  dnv_pkg::fault_t                 dot_fault;
  dnv_pkg::fault_t                 end_fault;
  logic [dnv_pkg::NAME_CNT_W-1:0]  name_cnt_upd;
  logic [dnv_pkg::LABEL_CNT_W-1:0] label_cnt_upd;
  logic                            after_dot_upd;
  logic                            hyphen_upd;
  dnv_pkg::fault_t                 fault_upd;

  always_comb begin
    is_dot  = (item.char_byte == dnv_pkg::CHAR_DOT);
    is_hyph = (item.char_byte == dnv_pkg::CHAR_HYPHEN);

    name_cnt_upd = (name_cnt_r == dnv_pkg::NAME_CNT_MAX) ? name_cnt_r
                                                         : name_cnt_r + 1'b1;
    dot_fault = close_label(after_dot_r, label_cnt_r, hyphen_r, max_label_len);

    if (is_dot) begin
      fault_upd     = (fault_r == dnv_pkg::FAULT_NONE) ? dot_fault : fault_r;
      label_cnt_upd = '0;
      after_dot_upd = 1'b1;
      hyphen_upd    = 1'b0;
    end else begin
      fault_upd = fault_r;
      if (fault_r == dnv_pkg::FAULT_NONE) begin
        if (!dnv_pkg::is_ldh(item.char_byte)) begin
          fault_upd = dnv_pkg::FAULT_BADCHAR;
        end else if (after_dot_r && is_hyph) begin
          fault_upd = dnv_pkg::FAULT_LEADHYPH;
        end
      end
      label_cnt_upd = (label_cnt_r == dnv_pkg::LABEL_CNT_MAX) ? label_cnt_r
                                                              : label_cnt_r + 1'b1;
      after_dot_upd = 1'b0;
      hyphen_upd    = is_hyph;
    end

    // Verdict at name end: the kept fault, else the last label's check,
    // with a length fault overriding both.
    end_fault = fault_upd;
    if (end_fault == dnv_pkg::FAULT_NONE) begin
      end_fault = close_label(after_dot_upd, label_cnt_upd, hyphen_upd,
                              max_label_len);
    end
    if ((name_cnt_upd == '0) || (name_cnt_upd > {1'b0, max_name_len})) begin
      end_fault = dnv_pkg::FAULT_LENGTH;
    end

    if (item.empty_name) begin
      track.has_result    = 1'b1;
      track.verdict.fault = dnv_pkg::FAULT_LENGTH;
    end else begin
      track.has_result    = item.end_of_name;
      track.verdict.fault = end_fault;
    end
    track.verdict.name_ok = (track.verdict.fault == dnv_pkg::FAULT_NONE);

    if (track.has_result) begin
      name_cnt_nxt  = '0;
      label_cnt_nxt = '0;
      after_dot_nxt = 1'b1;
      hyphen_nxt    = 1'b0;
      fault_nxt     = dnv_pkg::FAULT_NONE;
    end else begin
      name_cnt_nxt  = name_cnt_upd;
      label_cnt_nxt = label_cnt_upd;
      after_dot_nxt = after_dot_upd;
      hyphen_nxt    = hyphen_upd;
      fault_nxt     = fault_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_cnt_r  <= '0;
      label_cnt_r <= '0;
      after_dot_r <= 1'b1;
      hyphen_r    <= 1'b0;
      fault_r     <= dnv_pkg::FAULT_NONE;
    end else if (fire) begin
      name_cnt_r  <= name_cnt_nxt;
      label_cnt_r <= label_cnt_nxt;
      after_dot_r <= after_dot_nxt;
      hyphen_r    <= hyphen_nxt;
      fault_r     <= fault_nxt;
    end
  end

endmodule

### rtl/dnv_out_reg.sv
// Result register that holds one verdict beat until the sink takes it.
`timescale 1ns / 1ps

module dnv_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dnv_pkg::verdict_t verdict,
  output logic              can_load,
  dnv_out_if.source         out_beat
);

  logic              valid_r;
  dnv_pkg::verdict_t verdict_r;

  assign can_load            = !valid_r || out_beat.ready;
  assign out_beat.valid      = valid_r;
  assign out_beat.name_ok    = verdict_r.name_ok;
  assign out_beat.fault_code = verdict_r.fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict;
    end
  end

endmodule

### rtl/domain_name_validator.sv
// Top level of the domain name validator: LDH label checks on a byte stream.
`timescale 1ns / 1ps
// A byte beat that ends a name passes from the input register through the
// counter update into the result register once that register can take it.
// Throughput: one byte per cycle while the result sink keeps up, set by the update
// of the counters and flags that sit between the input register and the result register.
// Reset (rst_n low, synchronous): limits return to 255 and 63, the name state
// returns to the start of a name, and both beat registers empty.

module domain_name_validator (
  input  logic                                clk,
  input  logic                                rst_n,
  dnv_in_if.sink                              in_beat,
  dnv_out_if.source                           out_beat,
  input  logic                                cfg_we,
  input  logic [dnv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dnv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Limit registers. A write takes effect on the next cycle; the host must only
  // write them while no name is in flight, which the block does not enforce.
  logic [dnv_pkg::NAME_LEN_W-1:0]  max_name_r;
  logic [dnv_pkg::LABEL_LEN_W-1:0] max_label_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r  <= dnv_pkg::MAX_NAME_RESET;
      max_label_r <= dnv_pkg::MAX_LABEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dnv_pkg::CFG_MAX_NAME:  max_name_r  <= cfg_wdata;
        dnv_pkg::CFG_MAX_LABEL: max_label_r <= cfg_wdata[dnv_pkg::LABEL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The byte held in the input register is consumed when it either yields no
  // name, or its verdict can go into the result register this cycle. The
  // input register refills in the same cycle, so bytes stream without gaps
  // as long as the result sink keeps up.
  logic                s1_valid;
  dnv_pkg::in_item_t   s1_item;
  dnv_pkg::track_out_t track;
  logic                can_load;
  logic                fire;

  assign fire = s1_valid && (!track.has_result || can_load);

  dnv_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .take    (fire),
    .valid_r (s1_valid),
    .item_r  (s1_item)
  );

  // Counters, flags and the first fault of the current name. The empty-name
  // beat always closes the name with a length fault, dropping any partial name.
  dnv_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (s1_item),
    .max_name_len  (max_name_r),
    .max_label_len (max_label_r),
    .track         (track)
  );

  dnv_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire && track.has_result),
    .verdict  (track.verdict),
    .can_load (can_load),
    .out_beat (out_beat)
  );

endmodule
